>>> design/qpld_pkg.sv
package qpld_pkg;

    localparam int SampleW      = 16;
    localparam int DarkW        = 7;
    localparam int BrightW      = 8;
    localparam int LevelsW      = 64;
    localparam int StaleW       = 16;
    localparam int CodeW        = 8;
    localparam int NumInputs    = 4;
    localparam int NumLevelRegs = 4;
    localparam int AddrW        = 6;
    localparam int DataW        = 64;
    localparam int RegIdxW      = 3;
    localparam int LevelW       = 2;

    // Register map, byte address = 8 * index
    localparam logic [RegIdxW-1:0] RegDiode0Levels = 3'd0;
    localparam logic [RegIdxW-1:0] RegDiode1Levels = 3'd1;
    localparam logic [RegIdxW-1:0] RegDiode2Levels = 3'd2;
    localparam logic [RegIdxW-1:0] RegDiode3Levels = 3'd3;
    localparam logic [RegIdxW-1:0] RegStaleTicks   = 3'd4;

    localparam logic [StaleW-1:0]  StaleReset      = 16'd20;
    localparam logic [DarkW-1:0]   PulseEndDark    = 7'd3;
    localparam logic [BrightW-1:0] MinPulseBright  = 8'd2;

    // Per-diode result of one tick
    typedef struct packed {
        logic              fire;   // becomes valid this tick
        logic              drop;   // time since pulse exceeds limit
        logic [LevelW-1:0] level;  // quantized updated level
    } diode_status_t;

endpackage

>>> design/qpld_diode.sv
module qpld_diode
    import qpld_pkg::*;
#(
    parameter int DARK_RESYNC_TICKS = 110
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [SampleW-1:0] sample,
    input  logic [LevelsW-1:0] levels,
    input  logic [StaleW-1:0]  stale_ticks,
    output diode_status_t      status
);

    logic [DarkW-1:0]   dark_run_reg, dark_run_next;
    logic [BrightW-1:0] bright_run_reg, bright_run_next;
    logic [SampleW-1:0] peak_reg, peak_next;
    logic [SampleW-1:0] second_reg, second_next;
    logic [StaleW-1:0]  since_pulse_reg, since_pulse_next;
    logic [SampleW-1:0] held_reg, held_next;

    logic [SampleW-1:0] black, lvl1, lvl2, lvl3;
    logic [DarkW-1:0]   dark_inc;
    logic [SampleW:0]   pair_sum;
    logic               fire;

    assign black    = levels[15:0];
    assign lvl1     = levels[31:16];
    assign lvl2     = levels[47:32];
    assign lvl3     = levels[63:48];
    assign dark_inc = dark_run_reg + 1'b1;
    assign pair_sum = {1'b0, peak_reg} + {1'b0, second_reg};

    always_comb
    begin
        dark_run_next    = dark_run_reg;
        bright_run_next  = bright_run_reg;
        peak_next        = peak_reg;
        second_next      = second_reg;
        held_next        = held_reg;
        fire             = 1'b0;
        since_pulse_next = (since_pulse_reg == '1) ? since_pulse_reg
                                                   : since_pulse_reg + 1'b1;
        if (sample < black)
        begin
            dark_run_next = dark_inc;
            if (dark_inc == PulseEndDark)
            begin
                // short bright runs are discarded
                if (bright_run_reg > MinPulseBright)
                begin
                    fire             = 1'b1;
                    since_pulse_next = '0;
                    held_next        = pair_sum[SampleW:1];
                end
                peak_next       = '0;
                second_next     = '0;
                bright_run_next = '0;
            end
            else if (dark_inc == DarkW'(DARK_RESYNC_TICKS))
            begin
                fire             = 1'b1;
                since_pulse_next = '0;
                dark_run_next    = '0;
            end
        end
        else
        begin
            dark_run_next = '0;
            if (bright_run_reg != '1)
            begin
                bright_run_next = bright_run_reg + 1'b1;
            end
            if (sample > peak_reg)
            begin
                second_next = peak_reg;
                peak_next   = sample;
            end
            else if (sample > second_reg)
            begin
                second_next = sample;
            end
        end
    end

    always_comb
    begin
        status.fire = fire;
        status.drop = since_pulse_next > stale_ticks;
        if (held_next <= lvl1)
        begin
            status.level = 2'd0;
        end
        else if (held_next <= lvl2)
        begin
            status.level = 2'd1;
        end
        else if (held_next <= lvl3)
        begin
            status.level = 2'd2;
        end
        else
        begin
            status.level = 2'd3;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_run_reg    <= '0;
            bright_run_reg  <= '0;
            peak_reg        <= '0;
            second_reg      <= '0;
            since_pulse_reg <= '0;
            held_reg        <= '0;
        end
        else if (step)
        begin
            dark_run_reg    <= dark_run_next;
            bright_run_reg  <= bright_run_next;
            peak_reg        <= peak_next;
            second_reg      <= second_next;
            since_pulse_reg <= since_pulse_next;
            held_reg        <= held_next;
        end
    end

endmodule

>>> design/quad_photodiode_level_decoder.sv
// Quad photodiode level decoder.
// Input channel: one item per sampling tick, four 16-bit brightness samples
// (sample_a..sample_d = diodes 0..3) with in_valid / in_stall.
// Output channel: symbol_code (four 2-bit levels, diode i at bits 2i+1..2i)
// with out_valid / out_stall. Most ticks produce no item; one is produced
// when every diode has been marked valid by an ended pulse or a dark resync.
// Config: APB-style, 64-bit data, register i at byte address 8*i: per-diode
// threshold words (black, level one/two/three) and the stale tick limit.
// Timing: an accepted item is held in the input register; when it steps, the
// per-diode counters, peak trackers and quantizers update and load the result
// register, which raises out_valid. One item per cycle sustained unless an
// emitting tick waits on a stalled output; the limit is the state update loop.
// Stall: when a result waits stalled in the output register, a tick that
// would emit another is held in the input register and in_stall rises;
// ticks that emit nothing keep flowing.
// Reset: all counters, levels and marks clear, thresholds clear, stale limit
// returns to 20, both channels empty.
module quad_photodiode_level_decoder
    import qpld_pkg::*;
#(
    parameter int DIODE_COUNT       = 4,
    parameter int DARK_RESYNC_TICKS = 110
)
(
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [SampleW-1:0] sample_a,
    input  logic [SampleW-1:0] sample_b,
    input  logic [SampleW-1:0] sample_c,
    input  logic [SampleW-1:0] sample_d,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [CodeW-1:0]   symbol_code,
    // config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [AddrW-1:0]   paddr,
    input  logic [DataW-1:0]   pwdata,
    output logic [DataW-1:0]   prdata,
    output logic               pready
);

    // ---------------- configuration ----------------
    logic [RegIdxW-1:0] reg_idx;
    logic               cfg_write;
    logic [LevelsW-1:0] lvl_cfg [NumLevelRegs];
    logic [StaleW-1:0]  stale_reg;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[AddrW-1:3];
    assign cfg_write = psel && penable && pwrite;

    for (genvar r = 0; r < NumLevelRegs; r++)
    begin : g_lvl_cfg
        if (r < DIODE_COUNT)
        begin : g_stored
            logic [LevelsW-1:0] lvl_reg;
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    lvl_reg <= '0;
                end
                else if (cfg_write && reg_idx == RegIdxW'(r))
                begin
                    lvl_reg <= pwdata;
                end
            end
            assign lvl_cfg[r] = lvl_reg;
        end
        else
        begin : g_absent
            // no such diode: register reads as zero, writes ignored
            assign lvl_cfg[r] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_reg <= StaleReset;
        end
        else if (cfg_write && reg_idx == RegStaleTicks)
        begin
            stale_reg <= pwdata[StaleW-1:0];
        end
    end

    always_comb
    begin
        case (reg_idx)
            RegDiode0Levels: prdata = lvl_cfg[0];
            RegDiode1Levels: prdata = lvl_cfg[1];
            RegDiode2Levels: prdata = lvl_cfg[2];
            RegDiode3Levels: prdata = lvl_cfg[3];
            RegStaleTicks:   prdata = {{(DataW-StaleW){1'b0}}, stale_reg};
            default:         prdata = '0;
        endcase
    end

    // ---------------- input register ----------------
    logic               s1_valid_reg;
    logic [SampleW-1:0] s1_sample_reg [NumInputs];
    logic               in_accept;
    logic               step;
    logic               advance;
    logic               emit;

    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign step      = s1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_sample_reg[0] <= sample_a;
            s1_sample_reg[1] <= sample_b;
            s1_sample_reg[2] <= sample_c;
            s1_sample_reg[3] <= sample_d;
        end
    end

    // ---------------- per-diode channels ----------------
    diode_status_t          status [DIODE_COUNT];
    logic [DIODE_COUNT-1:0] marks_reg, marks_next;
    logic [CodeW-1:0]       code;

    for (genvar d = 0; d < DIODE_COUNT; d++)
    begin : g_diode
        logic [SampleW-1:0] smp;
        logic [LevelsW-1:0] lvl;
        if (d < NumInputs)
        begin : g_wired
            assign smp = s1_sample_reg[d];
            assign lvl = lvl_cfg[d];
        end
        else
        begin : g_spare
            // extra diodes see dark-free zero input and zero thresholds
            assign smp = '0;
            assign lvl = '0;
        end

        qpld_diode #(
            .DARK_RESYNC_TICKS (DARK_RESYNC_TICKS)
        ) u_diode (
            .clk         (clk),
            .rst_n       (rst_n),
            .step        (step),
            .sample      (smp),
            .levels      (lvl),
            .stale_ticks (stale_reg),
            .status      (status[d])
        );

        // fire sets the mark; otherwise a stale diode loses it
        assign marks_next[d] = status[d].fire ? 1'b1 :
                               status[d].drop ? 1'b0 : marks_reg[d];
    end

    always_comb
    begin
        code = '0;
        for (int d = 0; d < DIODE_COUNT; d++)
        begin
            if (d < CodeW / LevelW)
            begin
                code[LevelW*d +: LevelW] = status[d].level;
            end
        end
    end

    assign emit = &marks_next;

    // a tick that emits waits while a stalled result occupies the output
    assign advance = !emit || !out_valid || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg <= '0;
        end
        else if (step)
        begin
            marks_reg <= emit ? '0 : marks_next;
        end
    end

    // ---------------- output register ----------------
    logic             out_valid_reg;
    logic [CodeW-1:0] code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            code_reg <= code;
        end
    end

    assign out_valid   = out_valid_reg;
    assign symbol_code = code_reg;

`ifndef ASSERT_OFF
    a_marks_clear_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (step && emit) |=> (marks_reg == '0))
        else $error("valid marks not cleared after emitting a symbol");

    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step && emit))
        else $error("result appeared without an emitting tick");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with empty input register");

    a_blocked_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && emit && out_valid_reg && out_stall) |=> s1_valid_reg)
        else $error("emitting tick dropped while output stalled");
`endif

endmodule

>>> test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qpld_pkg::*;

    // Dark ticks that force a resync mark; passed down to the block as well.
    localparam int ResyncTicks = 110;
    // Cycles to let the pipe empty after the last result.
    localparam int IdleCycles  = 4;
    // Top register index the address decoder can see; indexes above stale_ticks are unmapped.
    localparam logic [RegIdxW-1:0] RegIdxLast = 3'd7;

    typedef logic [NumInputs-1:0][SampleW-1:0] tick_samples_t;
    typedef int unsigned per_diode_t [NumInputs];

    // ---------------------------------------------------------------------
    // DUT hookup
    // ---------------------------------------------------------------------
    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [SampleW-1:0] sample_a;
    logic [SampleW-1:0] sample_b;
    logic [SampleW-1:0] sample_c;
    logic [SampleW-1:0] sample_d;
    logic               out_valid;
    logic               out_stall;
    logic [CodeW-1:0]   symbol_code;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [AddrW-1:0]   paddr;
    logic [DataW-1:0]   pwdata;
    logic [DataW-1:0]   prdata;
    logic               pready;

    quad_photodiode_level_decoder #(
        .DIODE_COUNT       (NumInputs),
        .DARK_RESYNC_TICKS (ResyncTicks)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample_a    (sample_a),
        .sample_b    (sample_b),
        .sample_c    (sample_c),
        .sample_d    (sample_d),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .symbol_code (symbol_code),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 4 ns period
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ---------------------------------------------------------------------
    // Decoder shadow: configuration and per-diode state, advanced once per
    // accepted item, in acceptance order.
    // ---------------------------------------------------------------------
    logic [LevelsW-1:0] diode_cfg [NumInputs];   // {level3, level2, level1, black}
    logic [StaleW-1:0]  stale_limit;
    logic [DarkW-1:0]   dark_len   [NumInputs];
    logic [BrightW-1:0] bright_len [NumInputs];
    logic [SampleW-1:0] top_val    [NumInputs];
    logic [SampleW-1:0] next_val   [NumInputs];
    logic [SampleW-1:0] age        [NumInputs];  // ticks since last pulse
    logic [SampleW-1:0] held       [NumInputs];
    logic [NumInputs-1:0] marks;

    logic [CodeW-1:0] codes_due [$];   // symbol codes still owed by the block
    int unsigned      mismatches;
    int unsigned      items_sent;
    bit               idle_on;         // random gaps and stalls enabled

    function automatic void reset_model();
        for (int d = 0; d < NumInputs; d++)
        begin
            diode_cfg[d]  = '0;
            dark_len[d]   = '0;
            bright_len[d] = '0;
            top_val[d]    = '0;
            next_val[d]   = '0;
            age[d]        = '0;
            held[d]       = '0;
        end
        stale_limit = StaleReset;
        marks       = '0;
    endfunction

    // k = 0 black, 1..3 level thresholds
    function automatic logic [SampleW-1:0] cut(int d, int k);
        return diode_cfg[d][SampleW*k +: SampleW];
    endfunction

    // First matching threshold wins, so unordered thresholds need no special handling.
    function automatic logic [LevelW-1:0] level_code(int d);
        if (held[d] <= cut(d, 1))
            return 2'd0;
        if (held[d] <= cut(d, 2))
            return 2'd1;
        if (held[d] <= cut(d, 3))
            return 2'd2;
        return 2'd3;
    endfunction

    function automatic void advance_decoder(tick_samples_t s);
        logic             fired;
        logic [SampleW:0] sum;
        logic [CodeW-1:0] code;
        for (int d = 0; d < NumInputs; d++)
        begin
            fired = 1'b0;
            if (age[d] != '1)
                age[d] = age[d] + 1'b1;
            if (s[d] < cut(d, 0))
            begin
                dark_len[d] = dark_len[d] + 1'b1;
                if (dark_len[d] == PulseEndDark)
                begin
                    // pulse end; a bright run of two or less is thrown away
                    if (bright_len[d] > MinPulseBright)
                    begin
                        fired   = 1'b1;
                        age[d]  = '0;
                        sum     = {1'b0, top_val[d]} + {1'b0, next_val[d]};
                        held[d] = sum[SampleW:1];
                    end
                    top_val[d]    = '0;
                    next_val[d]   = '0;
                    bright_len[d] = '0;
                end
                else if (dark_len[d] == DarkW'(ResyncTicks))
                begin
                    // long dark stretch: mark valid, keep old level
                    fired       = 1'b1;
                    age[d]      = '0;
                    dark_len[d] = '0;
                end
            end
            else
            begin
                dark_len[d] = '0;
                if (bright_len[d] != '1)
                    bright_len[d] = bright_len[d] + 1'b1;
                if (s[d] > top_val[d])
                begin
                    next_val[d] = top_val[d];
                    top_val[d]  = s[d];
                end
                else if (s[d] > next_val[d])
                    next_val[d] = s[d];
            end
            if (fired)
                marks[d] = 1'b1;
            else if (age[d] > stale_limit)
                marks[d] = 1'b0;
        end
        if (&marks)
        begin
            code = '0;
            for (int d = 0; d < NumInputs; d++)
                code[LevelW*d +: LevelW] = level_code(d);
            marks = '0;
            codes_due.push_back(code);
        end
    endfunction

    function automatic void note_register(logic [RegIdxW-1:0] idx, logic [DataW-1:0] value);
        if (idx <= RegDiode3Levels)
            diode_cfg[idx - RegDiode0Levels] = value;
        else if (idx == RegStaleTicks)
            stale_limit = value[StaleW-1:0];
        // anything else is unmapped and ignored
    endfunction

    // ---------------------------------------------------------------------
    // Bus and stream drivers
    // ---------------------------------------------------------------------

    // APB write: setup phase, access phase, done on the edge with pready.
    task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [DataW-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        note_register(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [LevelsW-1:0] pack_levels(logic [SampleW-1:0] black,
                                                        logic [SampleW-1:0] lv1,
                                                        logic [SampleW-1:0] lv2,
                                                        logic [SampleW-1:0] lv3);
        return {lv3, lv2, lv1, black};
    endfunction

    task automatic write_stale(input logic [StaleW-1:0] limit);
        logic [DataW-1:0] value;
        value = {$urandom, $urandom};   // upper bits are don't-care
        value[StaleW-1:0] = limit;
        write_reg(RegStaleTicks, value);
    endtask

    // Send one item; the shadow advances at the accepting edge.
    task automatic push_tick(input tick_samples_t s);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19))
                @(negedge clk);
        end
        in_valid <= 1'b1;
        sample_a <= s[0];
        sample_b <= s[1];
        sample_c <= s[2];
        sample_d <= s[3];
        do
            @(posedge clk);
        while (in_stall);
        advance_decoder(s);
        items_sent++;
    endtask

    // Block must be idle before any register write.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (codes_due.size() != 0)
            @(posedge clk);
        repeat (IdleCycles)
            @(posedge clk);
    endtask

    function automatic logic [SampleW-1:0] dark_sample(int d);
        logic [SampleW-1:0] black;
        black = cut(d, 0);
        if (black == '0 || $urandom_range(0, 7) == 0)
            return '0;
        return SampleW'($urandom_range(black - 1, 0));
    endfunction

    function automatic logic [SampleW-1:0] bright_sample(int d);
        if ($urandom_range(0, 7) == 0)
            return '1;
        return SampleW'($urandom_range(16'hFFFF, cut(d, 0)));
    endfunction

    // One light pulse per diode: lead dark ticks, span bright ticks, then at
    // least three dark ticks (plus tail). With use_flat every bright item of
    // a diode carries flat[d], so its held pulse value is exactly flat[d].
    task automatic send_frame(input per_diode_t lead, input per_diode_t span,
                              input int unsigned tail, input tick_samples_t flat,
                              input bit use_flat);
        tick_samples_t s;
        int unsigned   frame_len;
        frame_len = 0;
        for (int d = 0; d < NumInputs; d++)
            if (lead[d] + span[d] > frame_len)
                frame_len = lead[d] + span[d];
        frame_len = frame_len + PulseEndDark + tail;
        for (int t = 0; t < frame_len; t++)
        begin
            for (int d = 0; d < NumInputs; d++)
                if (t >= lead[d] && t < lead[d] + span[d])
                    s[d] = use_flat ? flat[d] : bright_sample(d);
                else
                    s[d] = dark_sample(d);
            push_tick(s);
        end
    endtask

    task automatic send_noise();
        tick_samples_t s;
        for (int d = 0; d < NumInputs; d++)
            s[d] = SampleW'($urandom);
        push_tick(s);
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Reset config: black threshold zero, so every sample is bright and no
    // pulse can ever end. Nothing should come out.
    task automatic check_reset_defaults();
        push_tick({4{16'h0000}});
        push_tick({4{16'hFFFF}});
        repeat (10)
            send_noise();
    endtask

    // Ordered thresholds, flat pulses landing exactly on and just above each
    // threshold so every 2-bit level shows up in each flat frame.
    task automatic check_level_quantize();
        wait_idle();
        for (int d = 0; d < NumInputs; d++)
            write_reg(RegIdxW'(RegDiode0Levels + d),
                      pack_levels(16'h1000, 16'h4000, 16'h8000, 16'hC000));
        write_stale(StaleReset);
        send_frame('{0, 0, 0, 0}, '{3, 3, 3, 3}, 0,
                   {16'hFFFF, 16'hC000, 16'h8000, 16'h4000}, 1'b1);
        send_frame('{0, 1, 2, 0}, '{3, 4, 3, 5}, 1,
                   {16'h1000, 16'h4001, 16'h8001, 16'hC001}, 1'b1);
        // random bright values: level is the truncated mean of the top two
        send_frame('{0, 0, 1, 2}, '{6, 4, 3, 5}, 0, '0, 1'b0);
        // unordered thresholds on diode 1: level one above level two
        wait_idle();
        write_reg(RegDiode1Levels, pack_levels(16'h1000, 16'h8000, 16'h4000, 16'hC000));
        send_frame('{0, 0, 0, 0}, '{3, 3, 3, 3}, 0,
                   {16'h2000, 16'hD000, 16'h9000, 16'h6000}, 1'b1);
    endtask

    // A run of two bright ticks is thrown away and leaves that diode unmarked.
    task automatic check_short_run_discard();
        send_frame('{0, 0, 0, 0}, '{2, 3, 3, 3}, 0, '0, 1'b0);
        send_frame('{0, 0, 0, 0}, '{3, 3, 3, 3}, 0, '0, 1'b0);
        send_frame('{0, 0, 0, 0}, '{3, 1, 3, 2}, 1, '0, 1'b0);
        send_frame('{1, 0, 2, 0}, '{3, 3, 4, 3}, 0, '0, 1'b0);
    endtask

    // Mark drops only when age is strictly above the limit: diode 3 ending
    // exactly stale_ticks after the others still completes the code, one tick
    // later it does not. Stale limit zero keeps a mark for its own tick only.
    task automatic check_stale_drop();
        send_frame('{0, 0, 0, 20}, '{3, 3, 3, 3}, 0, '0, 1'b0);
        send_frame('{0, 0, 0, 21}, '{3, 3, 3, 3}, 0, '0, 1'b0);
        send_frame('{0, 0, 0, 0}, '{3, 3, 3, 3}, 0, '0, 1'b0);
        wait_idle();
        write_stale('0);
        send_frame('{0, 0, 0, 0}, '{4, 3, 5, 3}, 0, '0, 1'b0);
        send_frame('{0, 1, 0, 0}, '{3, 3, 3, 3}, 0, '0, 1'b0);
        send_frame('{0, 0, 0, 0}, '{3, 3, 3, 3}, 0, '0, 1'b0);
        wait_idle();
        write_stale(StaleReset);
    endtask

    // All diodes dark long enough to hit the resync count together.
    task automatic check_dark_resync();
        send_frame('{0, 0, 0, 0}, '{3, 3, 3, 3}, 0, '0, 1'b0);
        send_frame('{0, 0, 0, 0}, '{0, 0, 0, 0}, ResyncTicks, '0, 1'b0);
    endtask

    // Writes to the unmapped indexes must leave the map alone.
    task automatic check_unmapped_regs();
        wait_idle();
        for (int i = RegStaleTicks + 1; i <= RegIdxLast; i++)
            write_reg(RegIdxW'(i), '1);
        send_frame('{0, 0, 0, 0}, '{3, 3, 3, 3}, 0, '0, 1'b0);
    endtask

    task automatic random_setup();
        logic [SampleW-1:0] th [4];
        logic [SampleW-1:0] swap;
        for (int d = 0; d < NumInputs; d++)
        begin
            case ($urandom_range(0, 7))
                0:       th[0] = 16'h0001;
                1:       th[0] = SampleW'($urandom_range(16'hFFFF, 16'hC000));
                default: th[0] = SampleW'($urandom_range(16'h8000, 1));
            endcase
            for (int k = 1; k < 4; k++)
                th[k] = SampleW'($urandom);
            // mostly ordered, sometimes left scrambled
            if ($urandom_range(0, 3) != 0)
                for (int p = 0; p < 2; p++)
                    for (int k = 1; k < 3; k++)
                        if (th[k] > th[k+1])
                        begin
                            swap    = th[k];
                            th[k]   = th[k+1];
                            th[k+1] = swap;
                        end
            write_reg(RegIdxW'(RegDiode0Levels + d), pack_levels(th[0], th[1], th[2], th[3]));
        end
        case ($urandom_range(0, 7))
            0:       write_stale('0);
            1:       write_stale(16'd1);
            2:       write_stale('1);
            3:       write_stale(StaleW'($urandom));
            default: write_stale(StaleW'($urandom_range(40, 8)));
        endcase
    endtask

    // Mostly well-formed pulse frames with random content, some short or
    // missing runs, some raw noise. Phases cover both config extremes; the
    // last phase runs without gaps or stalls.
    task automatic check_random_traffic();
        per_diode_t  lead;
        per_diode_t  span;
        int unsigned phase_start;
        for (int phase = 0; phase < 6; phase++)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    for (int d = 0; d < NumInputs; d++)
                        write_reg(RegIdxW'(RegDiode0Levels + d), pack_levels(16'h0001, '0, '0, '0));
                    write_stale('1);
                end
                1:
                begin
                    for (int d = 0; d < NumInputs; d++)
                        write_reg(RegIdxW'(RegDiode0Levels + d), '1);
                    write_stale(16'd1);
                end
                default:
                    random_setup();
            endcase
            if (phase == 5)
                idle_on = 1'b0;
            phase_start = items_sent;
            while (items_sent - phase_start < 35)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                else
                begin
                    for (int d = 0; d < NumInputs; d++)
                    begin
                        lead[d] = $urandom_range(0, 3);
                        span[d] = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 2)
                                                                : $urandom_range(3, 8);
                    end
                    send_frame(lead, span, $urandom_range(0, 4), '0, 1'b0);
                end
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Result check: every accepted symbol_code against the oldest owed code
    // ---------------------------------------------------------------------
    logic [CodeW-1:0] owed_code;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (codes_due.size() == 0)
            begin
                $display("%0t: symbol_code expected none actual %h", $time, symbol_code);
                mismatches++;
            end
            else
            begin
                owed_code = codes_due.pop_front();
                if (symbol_code !== owed_code)
                begin
                    $display("%0t: symbol_code expected %h actual %h",
                             $time, owed_code, symbol_code);
                    mismatches++;
                end
            end
        end
    end

    // Receiver stall: random bursts, off once idle_on drops.
    initial
    begin
        int unsigned burst;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            burst = $urandom_range(1, 19);
            @(negedge clk);
            out_stall <= idle_on && ($urandom_range(0, 2) == 0);
            repeat (burst - 1)
                @(negedge clk);
        end
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        sample_a   = '0;
        sample_b   = '0;
        sample_c   = '0;
        sample_d   = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        mismatches = 0;
        items_sent = 0;
        idle_on    = 1'b1;
        reset_model();
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        check_reset_defaults();
        check_level_quantize();
        check_short_run_discard();
        check_stale_drop();
        check_dark_resync();
        check_unmapped_regs();
        check_random_traffic();

        wait_idle();
        if (mismatches == 0 && codes_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
